FILE: design/sre_pkg.sv
`default_nettype none
package sre_pkg;

    // channels computed; channels at or above this index read as zero
    localparam int CHANNEL_COUNT = 3;

    localparam int PIX_W    = 24;
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;
    localparam int NUM_NBR  = 8;
    localparam int MASK_W   = 4;

    // gradient and root widths
    localparam int GRAD_W   = 11;
    localparam int SQ_W     = 20;
    localparam int SUM_W    = SQ_W + 1;
    localparam int ROOT_W   = CH_W;
    localparam int RAD_W    = 2 * ROOT_W;

    // register stages inside one lane: gradient, square, sum, then one per root bit
    localparam int LANE_LAT   = 3 + ROOT_W;
    localparam int RESULT_LAT = LANE_LAT + 1;

    localparam logic [CH_W-1:0] MAG_MAX = '1;

    // neighbour positions in a window
    localparam int NBR_UL = 0;
    localparam int NBR_UM = 1;
    localparam int NBR_UR = 2;
    localparam int NBR_ML = 3;
    localparam int NBR_MR = 4;
    localparam int NBR_LL = 5;
    localparam int NBR_LM = 6;
    localparam int NBR_LR = 7;

    // border mask bits
    localparam int MB_LEFT  = 0;
    localparam int MB_RIGHT = 1;
    localparam int MB_UP    = 2;
    localparam int MB_DOWN  = 3;

    typedef logic [NUM_NBR-1:0][CH_W-1:0] t_win;

    typedef struct packed {
        logic             sat;
        logic [RAD_W-1:0] rad;
    } t_rad;

endpackage
`default_nettype wire

FILE: design/sre_sqrt.sv
`default_nettype none
module sre_sqrt (
    input  logic                      i_clk,
    input  sre_pkg::t_rad             i_rad,
    output logic [sre_pkg::CH_W-1:0]  o_mag
);
    import sre_pkg::*;

    t_rad              w_rad  [0:ROOT_W];
    logic [ROOT_W-1:0] w_root [0:ROOT_W];

    assign w_rad[0]  = i_rad;
    assign w_root[0] = '0;

    // one root bit per stage, msb first
    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [ROOT_W-1:0] w_try;
        logic [RAD_W-1:0]  w_try_sq;
        logic [ROOT_W-1:0] n_root;
        t_rad              r_rad;
        logic [ROOT_W-1:0] r_root;

        always_comb begin
            w_try    = w_root[k] | (ROOT_W'(1) << (ROOT_W - 1 - k));
            w_try_sq = RAD_W'(w_try) * RAD_W'(w_try);
            n_root   = (w_try_sq <= w_rad[k].rad) ? w_try : w_root[k];
        end

        always_ff @(posedge i_clk) begin
            r_rad  <= w_rad[k];
            r_root <= n_root;
        end

        assign w_rad[k+1]  = r_rad;
        assign w_root[k+1] = r_root;
    end

    assign o_mag = w_rad[ROOT_W].sat ? MAG_MAX : w_root[ROOT_W];

endmodule
`default_nettype wire

FILE: design/sre_lane.sv
`default_nettype none
module sre_lane (
    input  logic                        i_clk,
    input  sre_pkg::t_win               i_win,
    input  logic [sre_pkg::MASK_W-1:0]  i_mask,
    output logic [sre_pkg::CH_W-1:0]    o_mag
);
    import sre_pkg::*;

    t_win                     w_win;
    logic                     w_no_l, w_no_r, w_no_u, w_no_d;
    logic signed [GRAD_W-1:0] n_gx, n_gy;
    logic signed [GRAD_W-1:0] r_gx, r_gy;
    logic [SQ_W-1:0]          r_sqx, r_sqy;
    logic [SUM_W-1:0]         n_sum;
    t_rad                     r_rad;

    assign w_no_l = i_mask[MB_LEFT];
    assign w_no_r = i_mask[MB_RIGHT];
    assign w_no_u = i_mask[MB_UP];
    assign w_no_d = i_mask[MB_DOWN];

    // neighbors outside the image count as zero
    always_comb begin
        w_win         = i_win;
        if (w_no_u || w_no_l) w_win[NBR_UL] = '0;
        if (w_no_u)           w_win[NBR_UM] = '0;
        if (w_no_u || w_no_r) w_win[NBR_UR] = '0;
        if (w_no_l)           w_win[NBR_ML] = '0;
        if (w_no_r)           w_win[NBR_MR] = '0;
        if (w_no_d || w_no_l) w_win[NBR_LL] = '0;
        if (w_no_d)           w_win[NBR_LM] = '0;
        if (w_no_d || w_no_r) w_win[NBR_LR] = '0;
    end

    // sums stay within +-1020, so wrapping 11-bit arithmetic is exact
    always_comb begin
        n_gx = GRAD_W'(w_win[NBR_UL]) + GRAD_W'({w_win[NBR_ML], 1'b0})
             + GRAD_W'(w_win[NBR_LL]) - GRAD_W'(w_win[NBR_UR])
             - GRAD_W'({w_win[NBR_MR], 1'b0}) - GRAD_W'(w_win[NBR_LR]);
        n_gy = GRAD_W'(w_win[NBR_UL]) + GRAD_W'({w_win[NBR_UM], 1'b0})
             + GRAD_W'(w_win[NBR_UR]) - GRAD_W'(w_win[NBR_LL])
             - GRAD_W'({w_win[NBR_LM], 1'b0}) - GRAD_W'(w_win[NBR_LR]);
    end

    assign n_sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        r_gx      <= n_gx;
        r_gy      <= n_gy;
        // sign-extend first so the square is formed at full width
        r_sqx     <= SQ_W'(r_gx) * SQ_W'(r_gx);
        r_sqy     <= SQ_W'(r_gy) * SQ_W'(r_gy);
        // anything from 2^16 up has a root above 255
        r_rad.sat <= |n_sum[SUM_W-1:RAD_W];
        r_rad.rad <= n_sum[RAD_W-1:0];
    end

    sre_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_rad (r_rad),
        .o_mag (o_mag)
    );

endmodule
`default_nettype wire

FILE: design/sobel_rgb_edge_magnitude_unit.sv
`default_nettype none
// a request accepted at a clock edge passes the gradient, square, sum and root registers of
// its lane and then the output register; o_valid rises together with the result
// throughput: one request per cycle while busy is low; one pipelined lane per color channel,
// the 8-stage bit-per-stage root pipeline sets the depth, no stage is shared between requests
// reset: synchronous active low; clears the in-flight valids, busy is high for one cycle after
module sobel_rgb_edge_magnitude_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [sre_pkg::PIX_W-1:0]   i_up_left,
    input  logic [sre_pkg::PIX_W-1:0]   i_up_mid,
    input  logic [sre_pkg::PIX_W-1:0]   i_up_right,
    input  logic [sre_pkg::PIX_W-1:0]   i_mid_left,
    input  logic [sre_pkg::PIX_W-1:0]   i_mid_right,
    input  logic [sre_pkg::PIX_W-1:0]   i_low_left,
    input  logic [sre_pkg::PIX_W-1:0]   i_low_mid,
    input  logic [sre_pkg::PIX_W-1:0]   i_low_right,
    input  logic [sre_pkg::MASK_W-1:0]  i_border_mask,
    output logic                        o_valid,
    output logic [sre_pkg::CH_W-1:0]    o_red_magnitude,
    output logic [sre_pkg::CH_W-1:0]    o_green_magnitude,
    output logic [sre_pkg::CH_W-1:0]    o_blue_magnitude
);
    import sre_pkg::*;

    logic                     w_accept;
    logic                     r_busy;
    logic [LANE_LAT-1:0]      r_vpipe;
    logic                     r_valid;
    logic [NUM_NBR-1:0][PIX_W-1:0] w_pix;
    logic [CH_W-1:0]          w_mag [NUM_CH];
    logic [CH_W-1:0]          r_mag [NUM_CH];

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    always_comb begin
        w_pix         = '0;
        w_pix[NBR_UL] = i_up_left;
        w_pix[NBR_UM] = i_up_mid;
        w_pix[NBR_UR] = i_up_right;
        w_pix[NBR_ML] = i_mid_left;
        w_pix[NBR_MR] = i_mid_right;
        w_pix[NBR_LL] = i_low_left;
        w_pix[NBR_LM] = i_low_mid;
        w_pix[NBR_LR] = i_low_right;
    end

    // red in the top byte, blue in the bottom
    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        if (c < CHANNEL_COUNT) begin : g_lane
            t_win w_win;

            for (genvar n = 0; n < NUM_NBR; n++) begin : g_nbr
                assign w_win[n] = w_pix[n][PIX_W-1-CH_W*c -: CH_W];
            end

            sre_lane u_lane (
                .i_clk  (i_clk),
                .i_win  (w_win),
                .i_mask (i_border_mask),
                .o_mag  (w_mag[c])
            );
        end else begin : g_off
            assign w_mag[c] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_vpipe <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= 1'b0;
            r_vpipe <= {r_vpipe[LANE_LAT-2:0], w_accept};
            r_valid <= r_vpipe[LANE_LAT-1];
        end
    end

    // register the lane results for the three magnitude outputs
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_CH; c++) begin
            r_mag[c] <= w_mag[c];
        end
    end

    assign o_valid           = r_valid;
    assign o_red_magnitude   = r_mag[0];
    assign o_green_magnitude = r_mag[1];
    assign o_blue_magnitude  = r_mag[2];

`ifndef NO_ASSERTIONS
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, RESULT_LAT))
        else $error("result strobe without a matching request");

    a_busy_after_reset : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> busy)
        else $error("request taken right after reset");

    a_full_mask_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_border_mask == '1, RESULT_LAT)) |->
        (o_red_magnitude == '0 && o_green_magnitude == '0 && o_blue_magnitude == '0))
        else $error("fully masked window gave a nonzero magnitude");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/sobel_rgb_edge_magnitude_unit_test.sv
`timescale 1ns / 1ps

module sobel_rgb_edge_magnitude_unit_test;
    import sre_pkg::*;

    typedef struct packed {
        logic [NUM_NBR-1:0][PIX_W-1:0] nbr;
        logic [MASK_W-1:0]             border_mask;
    } window_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } magnitudes_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [PIX_W-1:0]    i_up_left;
    logic [PIX_W-1:0]    i_up_mid;
    logic [PIX_W-1:0]    i_up_right;
    logic [PIX_W-1:0]    i_mid_left;
    logic [PIX_W-1:0]    i_mid_right;
    logic [PIX_W-1:0]    i_low_left;
    logic [PIX_W-1:0]    i_low_mid;
    logic [PIX_W-1:0]    i_low_right;
    logic [MASK_W-1:0]   i_border_mask;
    logic                o_valid;
    logic [CH_W-1:0]     o_red_magnitude;
    logic [CH_W-1:0]     o_green_magnitude;
    logic [CH_W-1:0]     o_blue_magnitude;

    magnitudes_t pending_magnitudes[$];
    int          error_count = 0;

    sobel_rgb_edge_magnitude_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_up_left        (i_up_left),
        .i_up_mid         (i_up_mid),
        .i_up_right       (i_up_right),
        .i_mid_left       (i_mid_left),
        .i_mid_right      (i_mid_right),
        .i_low_left       (i_low_left),
        .i_low_mid        (i_low_mid),
        .i_low_right      (i_low_right),
        .i_border_mask    (i_border_mask),
        .o_valid          (o_valid),
        .o_red_magnitude  (o_red_magnitude),
        .o_green_magnitude(o_green_magnitude),
        .o_blue_magnitude (o_blue_magnitude)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    // floor of the square root, built one bit at a time from the top
    function automatic int floor_root(input int sq);
        int root;
        int trial;
        root = 0;
        for (int b = 11; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= sq) root = trial;
        end
        return root;
    endfunction

    function automatic magnitudes_t sobel_magnitudes(input window_t w);
        logic [PIX_W-1:0] px [NUM_NBR];
        logic             no_left;
        logic             no_right;
        logic             no_up;
        logic             no_down;
        int               v [NUM_NBR];
        int               gx;
        int               gy;
        int               root;
        logic [CH_W-1:0]  mag [NUM_CH];
        magnitudes_t      res;
        no_left  = w.border_mask[MB_LEFT];
        no_right = w.border_mask[MB_RIGHT];
        no_up    = w.border_mask[MB_UP];
        no_down  = w.border_mask[MB_DOWN];
        for (int k = 0; k < NUM_NBR; k++) px[k] = w.nbr[k];
        // outside neighbors read as zero, corners go with either edge
        if (no_up || no_left)   px[NBR_UL] = '0;
        if (no_up)              px[NBR_UM] = '0;
        if (no_up || no_right)  px[NBR_UR] = '0;
        if (no_left)            px[NBR_ML] = '0;
        if (no_right)           px[NBR_MR] = '0;
        if (no_down || no_left) px[NBR_LL] = '0;
        if (no_down)            px[NBR_LM] = '0;
        if (no_down || no_right) px[NBR_LR] = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            mag[c] = '0;
            if (c < CHANNEL_COUNT) begin
                for (int k = 0; k < NUM_NBR; k++) v[k] = int'(px[k][PIX_W-1-CH_W*c -: CH_W]);
                gx = v[NBR_UL] + 2 * v[NBR_ML] + v[NBR_LL]
                   - v[NBR_UR] - 2 * v[NBR_MR] - v[NBR_LR];
                gy = v[NBR_UL] + 2 * v[NBR_UM] + v[NBR_UR]
                   - v[NBR_LL] - 2 * v[NBR_LM] - v[NBR_LR];
                root = floor_root(gx * gx + gy * gy);
                mag[c] = (root > int'(MAG_MAX)) ? MAG_MAX : root[CH_W-1:0];
            end
        end
        res.red   = mag[0];
        res.green = mag[1];
        res.blue  = mag[2];
        return res;
    endfunction

    function automatic window_t random_window();
        window_t          w;
        int               kind;
        logic [PIX_W-1:0] base;
        kind = $urandom_range(0, 9);
        base = PIX_W'($urandom);
        for (int k = 0; k < NUM_NBR; k++) begin
            if (kind < 4) begin
                w.nbr[k] = PIX_W'($urandom);
            end else if (kind < 8) begin
                // low contrast keeps magnitudes under saturation
                for (int c = 0; c < NUM_CH; c++)
                    w.nbr[k][CH_W*c +: CH_W] = base[CH_W*c +: CH_W]
                                             ^ CH_W'($urandom_range(0, 15));
            end else begin
                w.nbr[k] = $urandom_range(0, 1) ? '1 : '0;
            end
        end
        w.border_mask = $urandom_range(0, 1) ? '0 : MASK_W'($urandom_range(0, 15));
        return w;
    endfunction

    task automatic drive_window(input window_t w);
        i_up_left     <= w.nbr[NBR_UL];
        i_up_mid      <= w.nbr[NBR_UM];
        i_up_right    <= w.nbr[NBR_UR];
        i_mid_left    <= w.nbr[NBR_ML];
        i_mid_right   <= w.nbr[NBR_MR];
        i_low_left    <= w.nbr[NBR_LL];
        i_low_mid     <= w.nbr[NBR_LM];
        i_low_right   <= w.nbr[NBR_LR];
        i_border_mask <= w.border_mask;
    endtask

    task automatic send_window(input window_t w);
        @(negedge i_clk);
        drive_window(w);
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_magnitudes.push_back(sobel_magnitudes(w));
    endtask

    // start low between requests, with noise on the data ports; n sets the length of the gap
    task automatic idle_cycles(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            drive_window(random_window());
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained(input int limit);
        int n;
        n = 0;
        while (pending_magnitudes.size() != 0 && n < limit) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    always @(posedge i_clk) begin
        magnitudes_t exp_mag;
        if (o_valid === 1'b1) begin
            if (pending_magnitudes.size() == 0) begin
                $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                         o_red_magnitude, o_green_magnitude, o_blue_magnitude);
                error_count++;
            end else begin
                exp_mag = pending_magnitudes.pop_front();
                if (o_red_magnitude !== exp_mag.red) begin
                    $display("%0t: red expected %0d actual %0d", $time,
                             exp_mag.red, o_red_magnitude);
                    error_count++;
                end
                if (o_green_magnitude !== exp_mag.green) begin
                    $display("%0t: green expected %0d actual %0d", $time,
                             exp_mag.green, o_green_magnitude);
                    error_count++;
                end
                if (o_blue_magnitude !== exp_mag.blue) begin
                    $display("%0t: blue expected %0d actual %0d", $time,
                             exp_mag.blue, o_blue_magnitude);
                    error_count++;
                end
            end
        end
    end

    task automatic test_edges_and_masks();
        window_t w;
        w = '0;
        send_window(w);
        w.nbr = '1;
        send_window(w);
        // left column bright: full horizontal gradient, then masked away
        w = '0;
        w.nbr[NBR_UL] = '1;
        w.nbr[NBR_ML] = '1;
        w.nbr[NBR_LL] = '1;
        send_window(w);
        w.border_mask[MB_LEFT] = 1'b1;
        send_window(w);
        w = '0;
        w.nbr[NBR_UR] = '1;
        w.nbr[NBR_MR] = '1;
        w.nbr[NBR_LR] = '1;
        send_window(w);
        w.border_mask[MB_RIGHT] = 1'b1;
        send_window(w);
        w = '0;
        w.nbr[NBR_UL] = '1;
        w.nbr[NBR_UM] = '1;
        w.nbr[NBR_UR] = '1;
        send_window(w);
        w.border_mask[MB_UP] = 1'b1;
        send_window(w);
        w = '0;
        w.nbr[NBR_LL] = '1;
        w.nbr[NBR_LM] = '1;
        w.nbr[NBR_LR] = '1;
        w.border_mask[MB_DOWN] = 1'b1;
        send_window(w);
        // tiny gradients on one corner, different per channel
        w = '0;
        w.nbr[NBR_UL] = 24'h010203;
        send_window(w);
        for (int m = 0; m < 16; m++) begin
            for (int k = 0; k < NUM_NBR; k++) w.nbr[k] = PIX_W'($urandom);
            w.border_mask = MASK_W'(m);
            send_window(w);
        end
        idle_cycles(1);
    endtask

    task automatic test_pause_until_drained();
        repeat (20) send_window(random_window());
        idle_cycles(1);
        wait_drained(1000);
        repeat (20) send_window(random_window());
        idle_cycles($urandom_range(1, 4));
    endtask

    task automatic test_random_bursts(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_window(random_window());
                sent++;
            end
            case ($urandom_range(0, 7))
                0, 1: ;
                2: idle_cycles($urandom_range(10, 30));
                default: idle_cycles($urandom_range(1, 6));
            endcase
        end
        idle_cycles(1);
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        drive_window('0);
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edges_and_masks();
        test_pause_until_drained();
        test_random_bursts(1680);

        wait_drained(2000);
        repeat (RESULT_LAT + 4) @(posedge i_clk);
        if (pending_magnitudes.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_magnitudes.size());
            error_count++;
        end
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
